// ===== rtl/core/vtp_pkg.sv =====
// Package for the VT100 escape parser: shared types, codes and constants.
// Used by the controller, the datapath, the top level and the checker.
// Depends on nothing.
package vtp_pkg;

	// Bytes that the parser recognizes.
	localparam logic [7:0] ESC_BYTE = 8'h1B;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_UP_E = 8'h45;
	localparam logic [7:0] CH_UP_D = 8'h44;
	localparam logic [7:0] CH_UP_H = 8'h48;
	localparam logic [7:0] CH_UP_J = 8'h4A;
	localparam logic [7:0] CH_UP_K = 8'h4B;
	localparam logic [7:0] CH_LO_F = 8'h66;
	localparam logic [7:0] CH_LO_M = 8'h6D;
	localparam logic [7:0] CH_LO_S = 8'h73;
	localparam logic [7:0] CH_LO_U = 8'h75;

	// Console geometry limits.
	localparam logic [6:0] MAX_ROWS = 7'd64;
	localparam logic [6:0] MAX_COLS = 7'd80;
	localparam logic [15:0] PARAM_SAT = 16'hFFFF;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_COLS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_ATTR = 2'd2;

	typedef enum logic [1:0] {
		MODE_NORMAL,
		MODE_ESC,
		MODE_CSI
	} mode_t;

	typedef enum logic [2:0] {
		CMD_PUT_CHAR,
		CMD_SET_CURSOR,
		CMD_FILL,
		CMD_CLEAR,
		CMD_SET_ATTR
	} cmd_code_t;

	// What the decoded item asks the controller to do.
	typedef enum logic [1:0] {
		ACT_NONE,
		ACT_ONE,
		ACT_SGR,
		ACT_ROWS
	} act_t;

	typedef enum logic [1:0] {
		SEL_DEC,
		SEL_SGR,
		SEL_ROW
	} emit_sel_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SGR,
		ST_SGR_OUT,
		ST_ROWS
	} ctl_state_t;

	typedef struct packed {
		logic accept;
		logic finish;
		logic start_sgr;
		logic step_sgr;
		logic start_rows;
		logic step_rows;
		logic emit;
		emit_sel_t sel;
	} dp_cmd_t;

	typedef struct packed {
		act_t act;
		logic sgr_last;
		logic rows_last;
		logic out_free;
	} dp_stat_t;

	// ANSI color number to VGA color bits: the bit order is reversed.
	function automatic logic [2:0] vga_color(input logic [2:0] c);
		vga_color = {c[0], c[1], c[2]};
	endfunction

endpackage

// ===== rtl/core/vtp_if.sv =====
// Handshake channels of the VT100 escape parser: terminal byte items and command items.
// Depends on nothing; payload widths are fixed.
interface vtp_byte_if;
	logic valid;
	logic ready;
	logic [7:0] char_in;
	logic [7:0] cursor_row;
	logic [7:0] cursor_col;
	logic [7:0] cur_attr;

	modport source (output valid, char_in, cursor_row, cursor_col, cur_attr, input ready);
	modport sink (input valid, char_in, cursor_row, cursor_col, cur_attr, output ready);
endinterface

interface vtp_cmd_if;
	logic valid;
	logic ready;
	logic [2:0] command;
	logic [7:0] row;
	logic [7:0] col;
	logic [6:0] fill_count;
	logic [7:0] value;
	logic last;

	modport source (output valid, command, row, col, fill_count, value, last, input ready);
	modport sink (input valid, command, row, col, fill_count, value, last, output ready);
endinterface

// ===== rtl/core/vtp_ctl.sv =====
// Controller state machine of the VT100 escape parser.
// Depends on vtp_pkg; drives the datapath through dp_cmd_t and reads dp_stat_t.
module vtp_ctl
	import vtp_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input dp_stat_t stat,
	output dp_cmd_t cmd
);

	ctl_state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.sel = SEL_DEC;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				unique case (stat.act)
					ACT_NONE: begin
						cmd.finish = 1'b1;
						state_d = ST_IDLE;
					end
					ACT_ONE: begin
						if (stat.out_free) begin
							cmd.emit = 1'b1;
							cmd.sel = SEL_DEC;
							cmd.finish = 1'b1;
							state_d = ST_IDLE;
						end
					end
					ACT_SGR: begin
						cmd.start_sgr = 1'b1;
						state_d = ST_SGR;
					end
					ACT_ROWS: begin
						cmd.start_rows = 1'b1;
						state_d = ST_ROWS;
					end
					default: state_d = ST_IDLE;
				endcase
			end
			ST_SGR: begin
				cmd.step_sgr = 1'b1;
				if (stat.sgr_last) begin
					state_d = ST_SGR_OUT;
				end
			end
			ST_SGR_OUT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.sel = SEL_SGR;
					cmd.finish = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_ROWS: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.sel = SEL_ROW;
					if (stat.rows_last) begin
						cmd.finish = 1'b1;
						state_d = ST_IDLE;
					end else begin
						cmd.step_rows = 1'b1;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== rtl/core/vtp_datapath.sv =====
// Datapath of the VT100 escape parser: parse state, CSI parameters, decode,
// attribute and row loops, configuration registers and the output register.
// Depends on vtp_pkg; commanded by vtp_ctl.
module vtp_datapath
	import vtp_pkg::*;
#(
	parameter int PARAM_BUF_CHARS = 32,
	parameter int MAX_PARAMS = 4
) (
	input logic clk,
	input logic arst_n,
	input dp_cmd_t cmd,
	output dp_stat_t stat,
	input logic [7:0] char_in,
	input logic [7:0] cursor_row,
	input logic [7:0] cursor_col,
	input logic [7:0] cur_attr,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [7:0] cfg_data,
	output logic out_valid,
	input logic out_ready,
	output logic [2:0] command,
	output logic [7:0] row,
	output logic [7:0] col,
	output logic [6:0] fill_count,
	output logic [7:0] value,
	output logic last
);

	localparam int CH_W = $clog2(PARAM_BUF_CHARS);
	localparam int PC_W = $clog2(MAX_PARAMS + 1);
	localparam int IX_W = $clog2(MAX_PARAMS);

	// Configuration registers.
	logic [6:0] screen_rows_q, screen_cols_q;
	logic [7:0] default_attr_q;

	// Parse state.
	mode_t mode_q;
	logic [CH_W-1:0] chars_q;
	logic [15:0] pv_q [MAX_PARAMS];
	logic [PC_W-1:0] pc_q;
	logic tok_q;
	logic [7:0] saved_row_q, saved_col_q;

	// Latched item.
	logic [7:0] char_q, row_q, col_q, attr_q;

	// Loop registers.
	logic [7:0] acc_q;
	logic [PC_W-1:0] left_q;
	logic [7:0] rcur_q, rend_q;

	// Output register.
	logic out_valid_q;
	logic [2:0] command_q;
	logic [7:0] row_q_out, col_q_out, value_q;
	logic [6:0] fill_q;
	logic last_q;

	// Decode results.
	act_t act;
	cmd_code_t dec_cmd;
	logic [7:0] dec_row, dec_col, dec_val, rows_start, rows_end;
	logic [6:0] dec_cnt, rows_eff, cols_eff;
	logic is_digit, is_param;
	logic [PC_W-1:0] cnt_tmp, cnt_eff;
	logic [15:0] p1, p2, cur_pv;
	logic [19:0] pv_next_wide;
	logic [15:0] pv_next;
	logic [8:0] col_inc;
	logic rows_last;

	function automatic logic [7:0] dec_sat(input logic [15:0] p);
		logic [15:0] m;
		m = p - 16'd1;
		if (p == 16'd0) dec_sat = 8'd0;
		else if (m > 16'd255) dec_sat = 8'd255;
		else dec_sat = m[7:0];
	endfunction

	function automatic logic [7:0] sgr_apply(input logic [7:0] a, input logic [15:0] p,
			input logic [7:0] dflt);
		logic [15:0] d;
		logic [15:0] e;
		d = p - 16'd30;
		e = p - 16'd40;
		if (p == 16'd0) sgr_apply = dflt;
		else if (p == 16'd1) sgr_apply = a | 8'h08;
		else if (p >= 16'd30 && p <= 16'd37) sgr_apply = {a[7:4], 1'b0, vga_color(d[2:0])};
		else if (p >= 16'd40 && p <= 16'd47) sgr_apply = {a[7], vga_color(e[2:0]), a[3:0]};
		else sgr_apply = a;
	endfunction

	// Effective screen size and parameter helpers.
	always_comb begin
		rows_eff = (screen_rows_q < MAX_ROWS) ? screen_rows_q : MAX_ROWS;
		cols_eff = (screen_cols_q < MAX_COLS) ? screen_cols_q : MAX_COLS;
		is_digit = (char_q >= CH_ZERO) && (char_q <= CH_NINE);
		is_param = is_digit || (char_q == CH_SEMI);
		cnt_tmp = (tok_q && pc_q < PC_W'(MAX_PARAMS)) ? pc_q + PC_W'(1) : pc_q;
		cnt_eff = (cnt_tmp == '0) ? PC_W'(1) : cnt_tmp;
		p1 = pv_q[0];
		p2 = (cnt_eff > PC_W'(1)) ? pv_q[1] : 16'd0;
		cur_pv = pv_q[pc_q[IX_W-1:0]];
		pv_next_wide = {1'b0, cur_pv, 3'b000} + {3'b000, cur_pv, 1'b0}
			+ {12'd0, char_q - CH_ZERO};
		pv_next = (pv_next_wide > {4'd0, PARAM_SAT}) ? PARAM_SAT : pv_next_wide[15:0];
		col_inc = {1'b0, col_q} + 9'd1;
		rows_last = (rcur_q == rend_q);
	end

	// Decode of the latched item against the parse state.
	always_comb begin
		act = ACT_NONE;
		dec_cmd = CMD_PUT_CHAR;
		dec_row = 8'd0;
		dec_col = 8'd0;
		dec_cnt = 7'd0;
		dec_val = 8'd0;
		rows_start = 8'd0;
		rows_end = 8'd0;
		unique case (mode_q)
			MODE_ESC: begin
				if (char_q == CH_UP_E || char_q == CH_UP_D) begin
					act = ACT_ONE;
					dec_cmd = CMD_SET_CURSOR;
					dec_row = (row_q == 8'd255) ? 8'd255 : row_q + 8'd1;
					dec_col = (char_q == CH_UP_D) ? col_q : 8'd0;
				end else if (char_q == CH_LO_U) begin
					act = ACT_ONE;
					dec_cmd = CMD_SET_CURSOR;
					dec_row = saved_row_q;
					dec_col = saved_col_q;
				end
			end
			MODE_CSI: begin
				if (!is_param) begin
					priority if (char_q == CH_UP_H || char_q == CH_LO_F) begin
						act = ACT_ONE;
						dec_cmd = CMD_SET_CURSOR;
						dec_row = dec_sat(p1);
						dec_col = dec_sat(p2);
					end else if (char_q == CH_UP_J) begin
						if (p1 == 16'd0) begin
							if (row_q < {1'b0, rows_eff}) begin
								act = ACT_ROWS;
								rows_start = row_q;
								rows_end = {1'b0, rows_eff - 7'd1};
							end
						end else if (p1 == 16'd1) begin
							if (rows_eff != 7'd0) begin
								act = ACT_ROWS;
								rows_end = (row_q < {1'b0, rows_eff}) ? row_q
									: {1'b0, rows_eff - 7'd1};
							end
						end else if (p1 == 16'd2) begin
							act = ACT_ONE;
							dec_cmd = CMD_CLEAR;
						end
					end else if (char_q == CH_UP_K) begin
						dec_cmd = CMD_FILL;
						dec_row = row_q;
						if (p1 == 16'd0) begin
							if (col_q < {1'b0, cols_eff}) begin
								act = ACT_ONE;
								dec_col = col_q;
								dec_cnt = cols_eff - col_q[6:0];
							end
						end else if (p1 == 16'd1) begin
							if (cols_eff != 7'd0) begin
								act = ACT_ONE;
								dec_cnt = (col_inc > {2'b00, cols_eff}) ? cols_eff
									: col_inc[6:0];
							end
						end else if (p1 == 16'd2) begin
							if (cols_eff != 7'd0) begin
								act = ACT_ONE;
								dec_cnt = cols_eff;
							end
						end
					end else if (char_q == CH_LO_M) begin
						act = ACT_SGR;
					end else if (char_q == CH_LO_U) begin
						act = ACT_ONE;
						dec_cmd = CMD_SET_CURSOR;
						dec_row = saved_row_q;
						dec_col = saved_col_q;
					end else begin
						act = ACT_NONE;
					end
				end
			end
			default: begin
				// Normal mode: anything but ESC is printed.
				if (char_q != ESC_BYTE) begin
					act = ACT_ONE;
					dec_val = char_q;
				end
			end
		endcase
	end

	assign stat = '{act: act, sgr_last: (left_q == PC_W'(1)), rows_last: rows_last,
		out_free: (!out_valid_q || out_ready)};

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_rows_q <= 7'd25;
			screen_cols_q <= 7'd80;
			default_attr_q <= 8'd7;
		end else if (cfg_we) begin
			if (cfg_index == REG_SCREEN_ROWS) screen_rows_q <= cfg_data[6:0];
			if (cfg_index == REG_SCREEN_COLS) screen_cols_q <= cfg_data[6:0];
			if (cfg_index == REG_DEFAULT_ATTR) default_attr_q <= cfg_data;
		end
	end

	// Item latch and loop registers.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			char_q <= char_in;
			row_q <= cursor_row;
			col_q <= cursor_col;
			attr_q <= cur_attr;
		end
		if (cmd.start_sgr) begin
			acc_q <= attr_q;
			left_q <= cnt_eff;
		end else if (cmd.step_sgr) begin
			acc_q <= sgr_apply(acc_q, pv_q[0], default_attr_q);
			left_q <= left_q - PC_W'(1);
		end
		if (cmd.start_rows) begin
			rcur_q <= rows_start;
			rend_q <= rows_end;
		end else if (cmd.step_rows) begin
			rcur_q <= rcur_q + 8'd1;
		end
	end

	// Parse state: committed when an item finishes; the SGR loop shifts parameters down.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
			chars_q <= '0;
			pc_q <= '0;
			tok_q <= 1'b0;
			saved_row_q <= 8'd0;
			saved_col_q <= 8'd0;
			for (int i = 0; i < MAX_PARAMS; i++) pv_q[i] <= 16'd0;
		end else if (cmd.step_sgr) begin
			for (int i = 0; i < MAX_PARAMS - 1; i++) pv_q[i] <= pv_q[i+1];
			pv_q[MAX_PARAMS-1] <= 16'd0;
		end else if (cmd.finish) begin
			unique case (mode_q)
				MODE_ESC: begin
					mode_q <= (char_q == CH_LBRACKET) ? MODE_CSI : MODE_NORMAL;
					if (char_q == CH_LBRACKET) begin
						chars_q <= '0;
						pc_q <= '0;
						tok_q <= 1'b0;
						for (int i = 0; i < MAX_PARAMS; i++) pv_q[i] <= 16'd0;
					end
					if (char_q == CH_LO_S) begin
						saved_row_q <= row_q;
						saved_col_q <= col_q;
					end
				end
				MODE_CSI: begin
					if (is_param) begin
						if (chars_q < CH_W'(PARAM_BUF_CHARS - 1)) begin
							chars_q <= chars_q + CH_W'(1);
							if (!is_digit) begin
								if (pc_q < PC_W'(MAX_PARAMS)) pc_q <= pc_q + PC_W'(1);
								tok_q <= 1'b0;
							end else begin
								tok_q <= 1'b1;
								if (pc_q < PC_W'(MAX_PARAMS)) begin
									pv_q[pc_q[IX_W-1:0]] <= pv_next;
								end
							end
						end
					end else begin
						mode_q <= MODE_NORMAL;
						chars_q <= '0;
						pc_q <= '0;
						tok_q <= 1'b0;
						for (int i = 0; i < MAX_PARAMS; i++) pv_q[i] <= 16'd0;
						if (char_q == CH_LO_S) begin
							saved_row_q <= row_q;
							saved_col_q <= col_q;
						end
					end
				end
				default: begin
					mode_q <= (char_q == ESC_BYTE) ? MODE_ESC : MODE_NORMAL;
				end
			endcase
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			unique case (cmd.sel)
				SEL_SGR: begin
					command_q <= CMD_SET_ATTR;
					row_q_out <= 8'd0;
					col_q_out <= 8'd0;
					fill_q <= 7'd0;
					value_q <= acc_q;
					last_q <= 1'b1;
				end
				SEL_ROW: begin
					command_q <= CMD_FILL;
					row_q_out <= rcur_q;
					col_q_out <= 8'd0;
					fill_q <= cols_eff;
					value_q <= 8'd0;
					last_q <= rows_last;
				end
				default: begin
					command_q <= dec_cmd;
					row_q_out <= dec_row;
					col_q_out <= dec_col;
					fill_q <= dec_cnt;
					value_q <= dec_val;
					last_q <= 1'b1;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign command = command_q;
	assign row = row_q_out;
	assign col = col_q_out;
	assign fill_count = fill_q;
	assign value = value_q;
	assign last = last_q;

endmodule

// ===== rtl/core/vt100_escape_parser_top.sv =====
// Top level of the VT100 escape parser: joins the controller and the datapath.
// Depends on vtp_pkg, vtp_if, vtp_ctl and vtp_datapath.
//
//   channel   dir   handshake          payload
//   byte_ch   in    valid/ready        char_in, cursor_row, cursor_col, cur_attr
//   cmd_ch    out   valid/ready        command, row, col, fill_count, value, last
//   cfg       in    cfg_we             cfg_index, cfg_data
//
// A byte item is accepted in the idle state and decoded in the next cycle, so plain bytes
// and single commands are emitted on decode when the output register is free.
// SGR steps through its parameters, then emits; erase display emits one fill per row.
// The single output register lets the next item be accepted while a command waits.
// Reset clears parse state, saved cursor and configuration to their defaults.
module vt100_escape_parser_top
	import vtp_pkg::*;
#(
	parameter int PARAM_BUF_CHARS = 32,
	parameter int MAX_PARAMS = 4
) (
	input logic clk,
	input logic arst_n,
	vtp_byte_if.sink byte_ch,
	vtp_cmd_if.source cmd_ch,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [7:0] cfg_data
);

	dp_cmd_t dp_cmd;
	dp_stat_t dp_stat;

	// Sequencer.
	vtp_ctl u_ctl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(byte_ch.valid),
		.in_ready(byte_ch.ready),
		.stat(dp_stat),
		.cmd(dp_cmd)
	);

	// Parse state and command generation.
	vtp_datapath #(
		.PARAM_BUF_CHARS(PARAM_BUF_CHARS),
		.MAX_PARAMS(MAX_PARAMS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(dp_cmd),
		.stat(dp_stat),
		.char_in(byte_ch.char_in),
		.cursor_row(byte_ch.cursor_row),
		.cursor_col(byte_ch.cursor_col),
		.cur_attr(byte_ch.cur_attr),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.out_valid(cmd_ch.valid),
		.out_ready(cmd_ch.ready),
		.command(cmd_ch.command),
		.row(cmd_ch.row),
		.col(cmd_ch.col),
		.fill_count(cmd_ch.fill_count),
		.value(cmd_ch.value),
		.last(cmd_ch.last)
	);

endmodule

// ===== rtl/core/vtp_checker.sv =====
// Port-level checker for the VT100 escape parser, bound to the top level.
// Depends on vtp_pkg and vt100_escape_parser_top.
module vtp_checker
	import vtp_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic [2:0] command,
	input logic [6:0] fill_count,
	input logic [7:0] value,
	input logic last
);

	// A stalled command item stays valid and keeps its command and value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(command) && $stable(value))
		else $error("command item changed while stalled");

	// Only defined command codes appear.
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> command <= CMD_SET_ATTR)
		else $error("undefined command code");

	// A printed character is always the only command of its byte.
	a_put_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && command == CMD_PUT_CHAR |-> last)
		else $error("put char not marked last");

	// Fills never exceed the column limit.
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && command == CMD_FILL |-> fill_count <= MAX_COLS)
		else $error("fill count too large");

endmodule

bind vt100_escape_parser_top vtp_checker u_vtp_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(cmd_ch.valid),
	.out_ready(cmd_ch.ready),
	.command(cmd_ch.command),
	.fill_count(cmd_ch.fill_count),
	.value(cmd_ch.value),
	.last(cmd_ch.last)
);

// ===== sim/tb_if.sv =====
// Interface instances used by the testbench come from the RTL file vtp_if.sv.
// This file holds the command and byte record types used by the testbench top.
// Depends on vtp_pkg.
package tb_cmd_pkg;
	import vtp_pkg::*;

	typedef struct {
		cmd_code_t cmd;
		logic [7:0] row;
		logic [7:0] col;
		logic [6:0] cnt;
		logic [7:0] val;
		logic last;
	} console_cmd_t;

	typedef struct {
		logic [7:0] ch;
		logic [7:0] crow;
		logic [7:0] ccol;
		logic [7:0] attr;
	} term_byte_t;
endpackage

// ===== sim/tb.sv =====
// Testbench for the VT100 escape parser: random and directed byte streams are checked
// command by command against a predictor of the parser written in this file.
// Depends on vtp_pkg, vtp_if, tb_cmd_pkg and the parser RTL.
module tb;
	import vtp_pkg::*;
	import tb_cmd_pkg::*;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [7:0] cfg_data;

	vtp_byte_if byte_ch();
	vtp_cmd_if cmd_ch();

	vt100_escape_parser_top dut (
		.clk(clk), .arst_n(arst_n), .byte_ch(byte_ch), .cmd_ch(cmd_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Predictor state.
	logic [6:0] rows_cfg, cols_cfg;
	logic [7:0] dflt_attr;
	mode_t pmode;
	int pchars, pcount;
	logic [15:0] pvals[4];
	logic tok_nonempty;
	logic [7:0] sv_row, sv_col;

	term_byte_t pending_bytes[$];
	console_cmd_t expected_cmds[$];
	int send_idle_pct, recv_stall_pct;
	int hold_cycles;
	int errors;
	int quiet_cycles;
	int n_accepted, n_popped;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [2:0] ansi_to_vga(input int c);
		logic [2:0] b;
		b = c[2:0];
		return {b[0], b[1], b[2]};
	endfunction

	task automatic push_cmd(input cmd_code_t c, input int r, input int cl, input int n,
		input int v);
		console_cmd_t e;
		e.cmd = c;
		e.row = r[7:0];
		e.col = cl[7:0];
		e.cnt = n[6:0];
		e.val = v[7:0];
		e.last = 1'b0;
		expected_cmds.push_back(e);
	endtask

	function automatic int clamp_dec(input int p);
		if (p == 0) return 0;
		return (p - 1 > 255) ? 255 : p - 1;
	endfunction

	// Finish a CSI sequence with its final byte.
	task automatic predict_csi(input term_byte_t b);
		int cnt, p1, p2, nrows, ncols, k, a, p;
		cnt = pcount;
		nrows = (rows_cfg < MAX_ROWS) ? rows_cfg : MAX_ROWS;
		ncols = (cols_cfg < MAX_COLS) ? cols_cfg : MAX_COLS;
		if (tok_nonempty && cnt < 4) cnt++;
		if (cnt == 0) cnt = 1;
		p1 = pvals[0];
		p2 = (cnt > 1) ? pvals[1] : 0;
		a = b.attr;
		case (b.ch)
			CH_UP_H, CH_LO_F: push_cmd(CMD_SET_CURSOR, clamp_dec(p1), clamp_dec(p2), 0, 0);
			CH_UP_J: begin
				if (p1 == 0) begin
					for (int r = b.crow; r < nrows; r++) push_cmd(CMD_FILL, r, 0, ncols, 0);
				end else if (p1 == 1) begin
					for (int r = 0; r < nrows && r <= b.crow; r++)
						push_cmd(CMD_FILL, r, 0, ncols, 0);
				end else if (p1 == 2) begin
					push_cmd(CMD_CLEAR, 0, 0, 0, 0);
				end
			end
			CH_UP_K: begin
				if (p1 == 0) begin
					if (b.ccol < ncols) push_cmd(CMD_FILL, b.crow, b.ccol, ncols - b.ccol, 0);
				end else if (p1 == 1) begin
					k = b.ccol + 1;
					if (k > ncols) k = ncols;
					if (k > 0) push_cmd(CMD_FILL, b.crow, 0, k, 0);
				end else if (p1 == 2) begin
					if (ncols > 0) push_cmd(CMD_FILL, b.crow, 0, ncols, 0);
				end
			end
			CH_LO_M: begin
				for (int i = 0; i < cnt && i < 4; i++) begin
					p = pvals[i];
					if (p == 0) a = dflt_attr;
					else if (p == 1) a = a | 8'h08;
					else if (p >= 30 && p <= 37) a = (a & 8'hF0) | ansi_to_vga(p - 30);
					else if (p >= 40 && p <= 47) a = (a & 8'h8F) | (ansi_to_vga(p - 40) << 4);
				end
				push_cmd(CMD_SET_ATTR, 0, 0, 0, a);
			end
			CH_LO_S: begin
				sv_row = b.crow;
				sv_col = b.ccol;
			end
			CH_LO_U: push_cmd(CMD_SET_CURSOR, sv_row, sv_col, 0, 0);
			default: ;
		endcase
		pchars = 0;
		pcount = 0;
		tok_nonempty = 1'b0;
		for (int i = 0; i < 4; i++) pvals[i] = '0;
	endtask

	// Work out the commands that one accepted byte causes.
	task automatic predict_byte(input term_byte_t b);
		int n_prev, v, nr;
		n_prev = expected_cmds.size();
		nr = (b.crow >= 255) ? 255 : b.crow + 1;
		if (pmode == MODE_ESC) begin
			pmode = MODE_NORMAL;
			case (b.ch)
				CH_LBRACKET: begin
					pmode = MODE_CSI;
					pchars = 0;
					pcount = 0;
					tok_nonempty = 1'b0;
					for (int i = 0; i < 4; i++) pvals[i] = '0;
				end
				CH_UP_E: push_cmd(CMD_SET_CURSOR, nr, 0, 0, 0);
				CH_UP_D: push_cmd(CMD_SET_CURSOR, nr, b.ccol, 0, 0);
				CH_LO_S: begin
					sv_row = b.crow;
					sv_col = b.ccol;
				end
				CH_LO_U: push_cmd(CMD_SET_CURSOR, sv_row, sv_col, 0, 0);
				default: ;
			endcase
		end else if (pmode == MODE_CSI) begin
			if ((b.ch >= CH_ZERO && b.ch <= CH_NINE) || b.ch == CH_SEMI) begin
				if (pchars < 31) begin
					pchars++;
					if (b.ch == CH_SEMI) begin
						if (pcount < 4) pcount++;
						tok_nonempty = 1'b0;
					end else begin
						tok_nonempty = 1'b1;
						if (pcount < 4) begin
							v = pvals[pcount] * 10 + (b.ch - CH_ZERO);
							pvals[pcount] = (v > 65535) ? PARAM_SAT : v[15:0];
						end
					end
				end
			end else begin
				predict_csi(b);
				pmode = MODE_NORMAL;
			end
		end else begin
			if (b.ch == ESC_BYTE) pmode = MODE_ESC;
			else push_cmd(CMD_PUT_CHAR, 0, 0, 0, b.ch);
		end
		if (expected_cmds.size() > n_prev) expected_cmds[$].last = 1'b1;
	endtask

	// Driver: offers pending items, idles at random, stalls the receiver's ready, changes inputs at the falling edge.
	always @(negedge clk) begin
		bit taken;
		if (arst_n) begin
			// The monitor counts accepts at the rising edge; retire the taken item here.
			taken = (n_popped != n_accepted);
			if (taken) begin
				void'(pending_bytes.pop_front());
				n_popped++;
			end
			if (pending_bytes.size() > 0 && (byte_ch.valid && !taken
					|| $urandom_range(99) >= send_idle_pct)) begin
				byte_ch.valid <= 1'b1;
				byte_ch.char_in <= pending_bytes[0].ch;
				byte_ch.cursor_row <= pending_bytes[0].crow;
				byte_ch.cursor_col <= pending_bytes[0].ccol;
				byte_ch.cur_attr <= pending_bytes[0].attr;
			end else begin
				byte_ch.valid <= 1'b0;
			end
			if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
				cmd_ch.ready <= 1'b0;
			end else begin
				cmd_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Monitor: predicts on accepted items and checks accepted commands.
	always @(posedge clk) begin
		console_cmd_t e;
		if (arst_n) begin
			if ((byte_ch.valid && byte_ch.ready) || (cmd_ch.valid && cmd_ch.ready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (byte_ch.valid && byte_ch.ready) begin
				predict_byte('{byte_ch.char_in, byte_ch.cursor_row, byte_ch.cursor_col,
					byte_ch.cur_attr});
				n_accepted <= n_accepted + 1;
			end
			if (cmd_ch.valid && cmd_ch.ready) begin
				if (expected_cmds.size() == 0) begin
					$error("unexpected command %0d", cmd_ch.command);
					errors++;
				end else begin
					e = expected_cmds.pop_front();
					if (cmd_ch.command !== e.cmd) begin
						$error("command: expected %0d actual %0d", e.cmd, cmd_ch.command);
						errors++;
					end
					if (cmd_ch.row !== e.row) begin
						$error("row: expected %0d actual %0d", e.row, cmd_ch.row);
						errors++;
					end
					if (cmd_ch.col !== e.col) begin
						$error("col: expected %0d actual %0d", e.col, cmd_ch.col);
						errors++;
					end
					if (cmd_ch.fill_count !== e.cnt) begin
						$error("fill_count: expected %0d actual %0d", e.cnt, cmd_ch.fill_count);
						errors++;
					end
					if (cmd_ch.value !== e.val) begin
						$error("value: expected %0d actual %0d", e.val, cmd_ch.value);
						errors++;
					end
					if (cmd_ch.last !== e.last) begin
						$error("last: expected %0d actual %0d", e.last, cmd_ch.last);
						errors++;
					end
				end
			end
		end
	end

	// Watchdog on cycles with no accepted item or command.
	always @(posedge clk) begin
		if (quiet_cycles > 20000) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic add_byte(input int ch, input int r = 0, input int c = 0, input int a = 7);
		pending_bytes.push_back('{ch[7:0], r[7:0], c[7:0], a[7:0]});
	endtask

	task automatic add_text(input string s, input int r = 0, input int c = 0, input int a = 7);
		for (int i = 0; i < s.len(); i++) add_byte(s[i], r, c, a);
	endtask

	task automatic drain();
		wait (pending_bytes.size() == 0 && !byte_ch.valid);
		wait (expected_cmds.size() == 0);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v[7:0];
		case (idx)
			REG_SCREEN_ROWS: rows_cfg = v[6:0];
			REG_SCREEN_COLS: cols_cfg = v[6:0];
			default: dflt_attr = v[7:0];
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// A random well-formed sequence with random content, or noise.
	task automatic add_random_seq();
		int r, c, a, k, np;
		string finals;
		string esc_finals;
		r = $urandom_range(255);
		c = $urandom_range(255);
		a = $urandom_range(255);
		if ($urandom_range(9) < 2) r = $urandom_range(30);
		if ($urandom_range(9) < 3) c = $urandom_range(90);
		finals = "HfJKmsuzA";
		esc_finals = "EDsuM";
		k = $urandom_range(9);
		if (k < 2) begin
			add_byte($urandom_range(255), r, c, a);
		end else if (k < 4) begin
			add_byte(ESC_BYTE, r, c, a);
			add_byte($urandom_range(3) == 0 ? $urandom_range(255) :
				esc_finals[$urandom_range(4)], r, c, a);
		end else begin
			add_byte(ESC_BYTE, r, c, a);
			add_byte(CH_LBRACKET, r, c, a);
			np = $urandom_range(5);
			for (int i = 0; i < np; i++) begin
				if (i > 0 || $urandom_range(4) == 0) add_byte(CH_SEMI, r, c, a);
				case ($urandom_range(3))
					0: add_text($sformatf("%0d", $urandom_range(2)), r, c, a);
					1: add_text($sformatf("%0d", 30 + $urandom_range(17)), r, c, a);
					2: add_text($sformatf("%0d", $urandom_range(300)), r, c, a);
					default: ;
				endcase
			end
			add_byte($urandom_range(15) == 0 ? $urandom_range(255) :
				finals[$urandom_range(finals.len() - 1)], r, c, a);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		byte_ch.valid = 1'b0;
		byte_ch.char_in = '0;
		byte_ch.cursor_row = '0;
		byte_ch.cursor_col = '0;
		byte_ch.cur_attr = '0;
		cmd_ch.ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 0;
		errors = 0;
		quiet_cycles = 0;
		n_accepted = 0;
		n_popped = 0;
		rows_cfg = 25;
		cols_cfg = 80;
		dflt_attr = 7;
		pmode = MODE_NORMAL;
		pchars = 0;
		pcount = 0;
		tok_nonempty = 1'b0;
		sv_row = 0;
		sv_col = 0;
		for (int i = 0; i < 4; i++) pvals[i] = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: field extremes, plain bytes, cursor moves, erases, SGR, save and restore.
		write_reg(REG_SCREEN_ROWS, 4);
		add_byte(8'h00, 0, 0, 0);
		add_byte(8'hFF, 255, 255, 255);
		add_text("\033E", 255, 3);
		add_text("\033D", 7, 9);
		add_text("\033s\033u", 5, 6);
		add_text("\033M\033\033x", 1, 1);
		add_text("\033[H\033[;5f\033[999;300H", 2, 2);
		add_text("\033[J\033[1J\033[2J\033[3J", 2, 5);
		add_text("\033[J", 200, 5);
		add_text("\033[K\033[1K\033[2K", 3, 79);
		add_text("\033[K", 3, 100);
		add_text("\033[0;1;31;44m\033[99m\033[;m", 0, 0, 8'hA5);
		add_text("\033[s\033[u\033[z", 9, 8);
		add_text("\033[9999999;1H", 0, 0);
		drain();

		// Size extremes and random phases with different idling.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin write_reg(REG_SCREEN_ROWS, 1); write_reg(REG_SCREEN_COLS, 1);
					write_reg(REG_DEFAULT_ATTR, 0); end
				1: begin write_reg(REG_SCREEN_ROWS, 64); write_reg(REG_SCREEN_COLS, 80);
					write_reg(REG_DEFAULT_ATTR, 255); end
				2: begin write_reg(REG_SCREEN_ROWS, 127); write_reg(REG_SCREEN_COLS, 127); end
				3: begin write_reg(REG_SCREEN_ROWS, 0); write_reg(REG_SCREEN_COLS, 0); end
				default: begin write_reg(REG_SCREEN_ROWS, 1 + $urandom_range(10));
					write_reg(REG_SCREEN_COLS, $urandom_range(1, 80));
					write_reg(REG_DEFAULT_ATTR, $urandom_range(255)); end
			endcase
			send_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? 53 : 0;
			recv_stall_pct = (ph % 4 == 2) ? 53 : 0;
			if (ph % 4 == 3) begin send_idle_pct = 12; recv_stall_pct = 12; end
			// A long receiver hold while plain bytes keep coming fills the block.
			if (ph == 1) begin
				hold_cycles = 300;
				add_text("abcdef", 0, 0, 7);
			end
			add_random_seq();
			drain();
		end
		if (errors == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end
endmodule
